FILE: hdl/vco_pkg.sv
// ----------------------------------------------------------------------------
// vco_pkg - shared constants for the vector cosine overlap block
// Stream field layout, shared multiplier limb width and the widths of the
// quotient and square root units.
// ----------------------------------------------------------------------------
package vco_pkg;

    // default block parameters
    localparam int DEF_MAX_LENGTH = 4096;
    localparam int DEF_ELEM_BITS  = 16;

    // stream field widths
    localparam int FIELD_W    = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OVL_W      = 17;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    // tuser bit positions on the result side
    localparam int USER_ZERO_BIT = 0;
    localparam int USER_OVF_BIT  = 1;

    // shared multiplier limb
    localparam int LIMB_W = 32;

    // quotient floor(dot^2 * 2^32 / (n1 * n2)) is at most 2^32
    localparam int QUOT_W = 33;

    // integer square root of the quotient, at most 65536
    localparam int ROOT_W     = 17;
    localparam int SQ_IN_W    = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 3;

    // overlap of exactly 1.0
    localparam logic [OVL_W-1:0] ONE_Q16 = 17'h10000;

endpackage

FILE: hdl/vco_mul.sv
// ----------------------------------------------------------------------------
// vco_mul - shared unsigned limb multiplier
// One LIMB_W x LIMB_W product per cycle, product registered.
// ----------------------------------------------------------------------------
module vco_mul (
    input  logic                          i_clk,
    input  logic [vco_pkg::LIMB_W-1:0]    i_a,
    input  logic [vco_pkg::LIMB_W-1:0]    i_b,
    output logic [2*vco_pkg::LIMB_W-1:0]  o_prod
);
    import vco_pkg::*;

    logic [2*LIMB_W-1:0] r_prod;

    // registered product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/vco_div.sv
// ----------------------------------------------------------------------------
// vco_div - restoring divider, one quotient bit per cycle
// Computes floor(num * 2^(QUOT_W-1) / den) for num <= den, den nonzero.
// ----------------------------------------------------------------------------
module vco_div #(
    parameter int PW = 86
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [PW-1:0]                 i_num,
    input  logic [PW-1:0]                 i_den,
    output logic                          o_done,
    output logic [vco_pkg::QUOT_W-1:0]    o_quot
);
    import vco_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic [PW:0]         r_rem;
    logic [PW-1:0]       r_den;
    logic [QUOT_W-1:0]   r_quot;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [PW:0]         w_diff;
    logic                w_ge;
    logic [PW:0]         w_new_rem;

    // trial subtraction
    assign w_diff    = r_rem - {1'b0, r_den};
    assign w_ge      = (r_rem >= {1'b0, r_den});
    assign w_new_rem = w_ge ? w_diff : r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {w_new_rem[PW-1:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/vco_sqrt.sv
// ----------------------------------------------------------------------------
// vco_sqrt - integer square root, one root bit per cycle
// Shift-subtract method over bit pairs of the radicand.
// ----------------------------------------------------------------------------
module vco_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vco_pkg::QUOT_W-1:0]    i_rad,
    output logic                          o_done,
    output logic [vco_pkg::ROOT_W-1:0]    o_root
);
    import vco_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_IN_W-1:0]  r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SQ_REM_W-1:0] w_rem_sh;
    logic [SQ_REM_W-1:0] w_trial;
    logic                w_ge;

    // bring down the next bit pair and try root*4+1
    assign w_rem_sh = {r_rem[SQ_REM_W-3:0], r_rad[SQ_IN_W-1 -: 2]};
    assign w_trial  = SQ_REM_W'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= SQ_IN_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_IN_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hdl/vector_cosine_overlap.sv
// ----------------------------------------------------------------------------
// vector_cosine_overlap - streaming absolute cosine similarity
// Accumulates dot product and squared norms of two vectors and reports
// |dot| / sqrt(n1 * n2) as unsigned Q1.16 on the last element pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one element pair per transaction: tdata holds ref_elem
//   (bits 15:0) and tgt_elem (bits 31:16), signed Q1.15; tlast marks the
//   final pair. Only the low ELEM_BITS bits of each element are used.
//   m_axis carries one result per vector: tdata holds overlap (bits 16:0),
//   tuser holds zero_norm (bit 0) and length_overflow (bit 1).
// Sequence:
//   a pair within the length limit is accepted, then its three products
//   and three accumulations go through one shared 32x32 multiplier;
//   a pair beyond MAX_LENGTH is counted but not multiplied. The last pair
//   adds the two wide products n1*n2 and dot*dot, formed limb by limb,
//   then the divider and the square root, and then loads the output
//   register. A zero norm skips the arithmetic.
// Reset clears all sums, the count and the output valid flag. When m_axis is
//   stalled the finished result waits in the output register; the next
//   vector can stream in meanwhile, and only a second finished result waits.
// ----------------------------------------------------------------------------
module vector_cosine_overlap #(
    parameter int MAX_LENGTH = vco_pkg::DEF_MAX_LENGTH,
    parameter int ELEM_BITS  = vco_pkg::DEF_ELEM_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [vco_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // ref_elem, tgt_elem
    input  logic                             s_axis_tlast,   // last_elem
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [vco_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // overlap
    output logic [vco_pkg::OUT_USER_W-1:0]   m_axis_tuser    // zero_norm, length_overflow
);
    import vco_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LENGTH + 2);
    localparam int NORM_W = 2 * ELEM_BITS - 1 + $clog2(MAX_LENGTH);
    localparam int DOT_W  = NORM_W + 1;
    localparam int NLIMB  = (NORM_W + LIMB_W - 1) / LIMB_W;
    localparam int OPW    = NLIMB * LIMB_W;
    localparam int PW     = 2 * NORM_W;
    localparam int ACC_W  = 2 * OPW;
    localparam int LC_W   = $clog2(NLIMB + 1);
    localparam int POS_W  = $clog2(2 * NLIMB);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ELEM  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_BMUL  = 4'd3;
    localparam logic [3:0] S_BACC  = 4'd4;
    localparam logic [3:0] S_BDONE = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]           r_state;
    logic [3:0]           n_state;

    // running sums
    logic signed [DOT_W-1:0] r_dot;
    logic [NORM_W-1:0]    r_ref_n;
    logic [NORM_W-1:0]    r_tgt_n;
    logic [CNT_W-1:0]     r_count;

    // current element pair
    logic [ELEM_BITS-1:0] r_mag_a;
    logic [ELEM_BITS-1:0] r_mag_b;
    logic                 r_neg;
    logic                 r_last;
    logic [1:0]           r_step;

    // wide product sequencing
    logic [OPW-1:0]       r_sa;
    logic [OPW-1:0]       r_sb;
    logic [OPW-1:0]       r_b0;
    logic [LC_W-1:0]      r_li;
    logic [LC_W-1:0]      r_lj;
    logic [POS_W-1:0]     r_pos_d;
    logic                 r_bpv;
    logic [ACC_W-1:0]     r_acc;
    logic                 r_phase;
    logic [PW-1:0]        r_den;

    // result staging and output register
    logic [OVL_W-1:0]     r_res_ovl;
    logic                 r_res_zero;
    logic                 r_mvalid;
    logic [OVL_W-1:0]     r_ovl;
    logic                 r_zero;
    logic                 r_ovf;

    // input field extraction
    logic [ELEM_BITS+FIELD_W-1:0] w_ref_ext;
    logic [ELEM_BITS+FIELD_W-1:0] w_tgt_ext;
    logic [ELEM_BITS-1:0] w_ref_raw;
    logic [ELEM_BITS-1:0] w_tgt_raw;
    logic                 w_ref_neg;
    logic                 w_tgt_neg;

    logic                 w_in_fire;
    logic                 w_out_free;
    logic [LIMB_W-1:0]    w_mul_a;
    logic [LIMB_W-1:0]    w_mul_b;
    logic [2*LIMB_W-1:0]  w_prod;
    logic [DOT_W-1:0]     w_prod_dot;
    logic [NORM_W-1:0]    w_prod_norm;
    logic [DOT_W-1:0]     w_dot_abs;
    logic                 w_last_issue;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [QUOT_W-1:0]    w_quot;
    logic                 w_sqrt_done;
    logic [ROOT_W-1:0]    w_root;

    // element fields, low ELEM_BITS as two's complement
    assign w_ref_ext = {{ELEM_BITS{1'b0}}, s_axis_tdata[FIELD_W-1:0]};
    assign w_tgt_ext = {{ELEM_BITS{1'b0}}, s_axis_tdata[2*FIELD_W-1:FIELD_W]};
    assign w_ref_raw = w_ref_ext[ELEM_BITS-1:0];
    assign w_tgt_raw = w_tgt_ext[ELEM_BITS-1:0];
    assign w_ref_neg = w_ref_raw[ELEM_BITS-1];
    assign w_tgt_neg = w_tgt_raw[ELEM_BITS-1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mvalid || m_axis_tready;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_ELEM) begin
            case (r_step)
                2'd0: begin
                    w_mul_a = LIMB_W'(r_mag_a);
                    w_mul_b = LIMB_W'(r_mag_b);
                end
                2'd1: begin
                    w_mul_a = LIMB_W'(r_mag_a);
                    w_mul_b = LIMB_W'(r_mag_a);
                end
                2'd2: begin
                    w_mul_a = LIMB_W'(r_mag_b);
                    w_mul_b = LIMB_W'(r_mag_b);
                end
                default: begin
                    w_mul_a = '0;
                    w_mul_b = '0;
                end
            endcase
        end else if (r_state == S_BMUL) begin
            w_mul_a = r_sa[LIMB_W-1:0];
            w_mul_b = r_sb[LIMB_W-1:0];
        end
    end

    vco_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_prod_dot  = DOT_W'(w_prod);
    assign w_prod_norm = NORM_W'(w_prod);
    assign w_dot_abs   = r_dot[DOT_W-1] ? (DOT_W'(0) - r_dot) : r_dot;
    assign w_last_issue = (r_li == LC_W'(NLIMB - 1)) && (r_lj == LC_W'(NLIMB - 1));
    assign w_div_start  = (r_state == S_BDONE) && r_phase;

    vco_div #(
        .PW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc[PW-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    vco_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_rad   (w_quot),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (r_count < CNT_W'(MAX_LENGTH)) begin
                        n_state = S_ELEM;
                    end else if (s_axis_tlast) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_ELEM: begin
                if (r_step == 2'd3) begin
                    n_state = r_last ? S_CHK : S_IDLE;
                end
            end
            S_CHK: begin
                n_state = (r_ref_n == '0 || r_tgt_n == '0) ? S_OUT : S_BMUL;
            end
            S_BMUL: begin
                if (w_last_issue) begin
                    n_state = S_BACC;
                end
            end
            S_BACC: begin
                n_state = S_BDONE;
            end
            S_BDONE: begin
                n_state = r_phase ? S_DIV : S_BMUL;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dot    <= '0;
            r_ref_n  <= '0;
            r_tgt_n  <= '0;
            r_count  <= '0;
            r_step   <= '0;
            r_bpv    <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bpv   <= (r_state == S_BMUL);

            // element count, saturating one past the limit
            if (w_in_fire) begin
                if (r_count < CNT_W'(MAX_LENGTH)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_count <= CNT_W'(MAX_LENGTH + 1);
                end
            end

            // element products land in the cycle after issue
            if (w_in_fire) begin
                r_step <= '0;
            end else if (r_state == S_ELEM) begin
                r_step <= r_step + 1'b1;
                case (r_step)
                    2'd1: r_dot   <= r_neg ? (r_dot - w_prod_dot) : (r_dot + w_prod_dot);
                    2'd2: r_ref_n <= r_ref_n + w_prod_norm;
                    2'd3: r_tgt_n <= r_tgt_n + w_prod_norm;
                    default: r_dot <= r_dot;
                endcase
            end

            // result transfer and clearing of the vector state
            if (r_state == S_OUT && w_out_free) begin
                r_mvalid <= 1'b1;
                r_dot    <= '0;
                r_ref_n  <= '0;
                r_tgt_n  <= '0;
                r_count  <= '0;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // element capture
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mag_a <= w_ref_neg ? (ELEM_BITS'(0) - w_ref_raw) : w_ref_raw;
            r_mag_b <= w_tgt_neg ? (ELEM_BITS'(0) - w_tgt_raw) : w_tgt_raw;
            r_neg   <= w_ref_neg ^ w_tgt_neg;
            r_last  <= s_axis_tlast;
        end
    end

    // wide product: limb schoolbook through the shared multiplier
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_sa    <= OPW'(r_ref_n);
            r_sb    <= OPW'(r_tgt_n);
            r_b0    <= OPW'(r_tgt_n);
            r_li    <= '0;
            r_lj    <= '0;
            r_phase <= 1'b0;
            r_acc   <= '0;
        end else if (r_state == S_BDONE) begin
            r_den   <= r_acc[PW-1:0];
            r_sa    <= OPW'(w_dot_abs);
            r_sb    <= OPW'(w_dot_abs);
            r_b0    <= OPW'(w_dot_abs);
            r_li    <= '0;
            r_lj    <= '0;
            r_phase <= 1'b1;
            if (!r_phase) begin
                r_acc <= '0;
            end
        end else begin
            if (r_state == S_BMUL) begin
                r_pos_d <= POS_W'(r_li) + POS_W'(r_lj);
                if (r_lj == LC_W'(NLIMB - 1)) begin
                    r_lj <= '0;
                    r_li <= r_li + 1'b1;
                    r_sa <= r_sa >> LIMB_W;
                    r_sb <= r_b0;
                end else begin
                    r_lj <= r_lj + 1'b1;
                    r_sb <= r_sb >> LIMB_W;
                end
            end
            if (r_bpv) begin
                r_acc <= r_acc + (ACC_W'(w_prod) << (r_pos_d * LIMB_W));
            end
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_res_ovl  <= '0;
            r_res_zero <= (r_ref_n == '0 || r_tgt_n == '0);
        end else if (r_state == S_SQRT && w_sqrt_done) begin
            r_res_ovl <= OVL_W'(w_root);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_ovl  <= r_res_ovl;
            r_zero <= r_res_zero;
            r_ovf  <= (r_count > CNT_W'(MAX_LENGTH));
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = OUT_DATA_W'(r_ovl);
    assign m_axis_tuser  = {r_ovf, r_zero};

    // checks
    a_zero_means_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_ZERO_BIT] |-> r_ovl == '0)
        else $error("zero norm result carries a nonzero overlap");

    a_overlap_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_ovl <= ONE_Q16)
        else $error("overlap above 1.0");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LENGTH + 1))
        else $error("element count past saturation");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside its state");

endmodule
